>>> src/sliding_window_frame_rate_meter_defines.svh
// Assertion helpers used by the back end RTL file.
`ifndef SLIDING_WINDOW_FRAME_RATE_METER_DEFINES_SVH
`define SLIDING_WINDOW_FRAME_RATE_METER_DEFINES_SVH

// Same-cycle implication, skipped while in reset.
`define SWFRM_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swfrm assertion failed");

// Next-cycle implication, skipped while in reset.
`define SWFRM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swfrm assertion failed");

`endif

>>> src/swfrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swfrm_pkg;

  // Input mode codes
  localparam logic MODE_START = 1'b0;

  // Item kind after classification
  typedef enum logic {
    EV_START = 1'b0,
    EV_FRAME = 1'b1
  } ev_kind_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_PUSH
  } bk_state_t;

  // Config register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_CAP    = 1'b1;

  localparam logic [31:0] WINDOW_RESET = 32'd1000000;
  localparam logic [31:0] CAP_RESET    = 32'd50000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] window_ticks;
    logic [31:0] delta_cap_ticks;
  } cfg_regs_t;

endpackage

`default_nettype wire

>>> src/swfrm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module swfrm_front #(
  parameter int unsigned STAMP_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [STAMP_BITS-1:0] now_time,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output swfrm_pkg::ev_kind_t        q_kind,
  output logic [STAMP_BITS-1:0]      q_now
);

  logic held_valid;

  assign in_ready = !held_valid || q_ready;
  assign q_valid  = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_kind <= (mode == swfrm_pkg::MODE_START) ? swfrm_pkg::EV_START : swfrm_pkg::EV_FRAME;
      q_now  <= now_time;
    end
  end

endmodule

`default_nettype wire

>>> src/swfrm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module swfrm_queue #(
  parameter int unsigned DATA_W = 49
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data
);

  localparam int unsigned PTR_W  = (swfrm_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(swfrm_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(swfrm_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [swfrm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = (fill != FILL_W'(swfrm_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(swfrm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

`default_nettype wire

>>> src/swfrm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module swfrm_back #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned STAMP_BITS = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire swfrm_pkg::cfg_regs_t             cfg,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire swfrm_pkg::ev_kind_t              q_kind,
  input  wire logic [STAMP_BITS-1:0]            q_now,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [31:0]                           frame_delta,
  output logic [STAMP_BITS-1:0]                 elapsed_time,
  output logic [$clog2(RING_DEPTH+1)-1:0]       frames_in_window
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned DW    = (STAMP_BITS > 32) ? STAMP_BITS : 32;

  swfrm_pkg::bk_state_t state, state_next;

  logic [IDX_W-1:0]      head, head_next, head_inc;
  logic [CNT_W-1:0]      count, count_next;
  logic [STAMP_BITS-1:0] start_time;
  logic [STAMP_BITS-1:0] last_stamp;
  logic [STAMP_BITS-1:0] cur_now;
  logic [STAMP_BITS-1:0] diff;
  logic                  fwd;
  logic [STAMP_BITS-1:0] elapsed;

  logic [STAMP_BITS-1:0] stamp_ring [RING_DEPTH];
  logic [STAMP_BITS-1:0] rdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_addr;
  logic [STAMP_BITS-1:0] mem_wdata;

  logic [STAMP_BITS-1:0] prev;
  logic [STAMP_BITS-1:0] age;
  logic                  expire;
  logic                  full;
  logic [CNT_W:0]        addr_sum;
  logic [IDX_W-1:0]      wr_addr;
  logic                  load_out;
  logic                  take;
  logic [31:0]           delta_val;

  assign take     = q_valid && q_ready;
  assign head_inc = (head == IDX_W'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
  assign prev     = (count != '0) ? last_stamp : start_time;
  assign age      = cur_now - rdata;
  assign expire   = (cur_now >= rdata) &&
                    (DW'(age) > DW'(cfg.window_ticks));
  assign full     = (count == CNT_W'(RING_DEPTH));
  assign addr_sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign wr_addr  = (addr_sum >= (CNT_W + 1)'(RING_DEPTH)) ?
                    IDX_W'(addr_sum - (CNT_W + 1)'(RING_DEPTH)) : IDX_W'(addr_sum);
  assign delta_val = !fwd ? 32'd0 :
                     (DW'(diff) > DW'(cfg.delta_cap_ticks)) ? cfg.delta_cap_ticks :
                     32'(DW'(diff));

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = wr_addr;
    mem_wdata  = cur_now;
    load_out   = 1'b0;
    unique case (state)
      swfrm_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_kind == swfrm_pkg::EV_START) begin
            head_next  = '0;
            count_next = CNT_W'(1);
            mem_we     = 1'b1;
            mem_addr   = '0;
            mem_wdata  = q_now;
          end else begin
            state_next = swfrm_pkg::BK_READ;
          end
        end
      end
      swfrm_pkg::BK_READ: begin
        state_next = (count == '0) ? swfrm_pkg::BK_PUSH : swfrm_pkg::BK_CHECK;
      end
      swfrm_pkg::BK_CHECK: begin
        if (expire) begin
          head_next  = head_inc;
          count_next = count - 1'b1;
          state_next = swfrm_pkg::BK_READ;
        end else begin
          state_next = swfrm_pkg::BK_PUSH;
        end
      end
      swfrm_pkg::BK_PUSH: begin
        if (!out_valid || out_ready) begin
          mem_we     = 1'b1;
          load_out   = 1'b1;
          head_next  = full ? head_inc : head;
          count_next = full ? count : count + 1'b1;
          state_next = swfrm_pkg::BK_IDLE;
        end
      end
      default: state_next = swfrm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= swfrm_pkg::BK_IDLE;
      head       <= '0;
      count      <= '0;
      start_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (take && q_kind == swfrm_pkg::EV_START) start_time <= q_now;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame bookkeeping, staged at pop time
  always_ff @(posedge clk) begin
    if (take && q_kind == swfrm_pkg::EV_START) last_stamp <= q_now;
    if (take && q_kind == swfrm_pkg::EV_FRAME) begin
      cur_now <= q_now;
      diff    <= q_now - prev;
      fwd     <= (q_now >= prev);
      elapsed <= q_now - start_time;
    end
    if (load_out) begin
      last_stamp       <= cur_now;
      frame_delta      <= delta_val;
      elapsed_time     <= elapsed;
      frames_in_window <= count_next;
    end
  end

  // stamp ring: one write port, one registered read at the oldest slot
  always_ff @(posedge clk) begin
    if (mem_we) stamp_ring[mem_addr] <= mem_wdata;
    rdata <= stamp_ring[head];
  end

`include "sliding_window_frame_rate_meter_defines.svh"

  `SWFRM_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(RING_DEPTH))
  `SWFRM_ASSERT_NOW(a_check_nonempty, clk, rst, state == swfrm_pkg::BK_CHECK, count != '0)
  `SWFRM_ASSERT_NEXT(a_push_emits, clk, rst, load_out, out_valid && state == swfrm_pkg::BK_IDLE)
  `SWFRM_ASSERT_NEXT(a_expire_shrinks, clk, rst, state == swfrm_pkg::BK_CHECK && expire, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

>>> src/sliding_window_frame_rate_meter.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------
// input    | in_valid/in_ready  | mode, now_time
// result   | out_valid/out_ready| frame_delta, elapsed_time, frames_in_window
// config   | cfg_write          | cfg_index, cfg_data (no wait, no read-back)
//
// A start item is taken in the idle state; a frame item steps through read,
// check and push (read and push only with an empty ring), plus a read and a
// check per expired ring entry over the single read port of the stamp ring,
// plus any wait on out_ready. Front stage and queue each register the item.
// rst is synchronous: config returns to its reset values, ring empty.
// A stalled result stalls only the back end; front register and queue keep
// taking items until they hold three.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_frame_rate_meter #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned STAMP_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        mode,
  input  wire logic [STAMP_BITS-1:0]       now_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [31:0]                      frame_delta,
  output logic [STAMP_BITS-1:0]            elapsed_time,
  output logic [$clog2(RING_DEPTH+1)-1:0]  frames_in_window
);

  // Queue entry carries the item kind above the time stamp.
  localparam int unsigned QW = STAMP_BITS + 1;

  swfrm_pkg::cfg_regs_t cfg;

  logic                  f_valid;
  logic                  f_ready;
  swfrm_pkg::ev_kind_t   f_kind;
  logic [STAMP_BITS-1:0] f_now;

  logic                  b_valid;
  logic                  b_ready;
  logic [QW-1:0]         b_data;
  swfrm_pkg::ev_kind_t   b_kind;
  logic [STAMP_BITS-1:0] b_now;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks    <= swfrm_pkg::WINDOW_RESET;
      cfg.delta_cap_ticks <= swfrm_pkg::CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swfrm_pkg::CFG_WINDOW: cfg.window_ticks    <= cfg_data;
        swfrm_pkg::CFG_CAP:    cfg.delta_cap_ticks <= cfg_data;
      endcase
    end
  end

  // Front: accept and classify.
  swfrm_front #(
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .now_time (now_time),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_kind   (f_kind),
    .q_now    (f_now)
  );

  // Short queue decoupling front from back.
  swfrm_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_kind, f_now}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign b_kind = swfrm_pkg::ev_kind_t'(b_data[QW-1]);
  assign b_now  = b_data[STAMP_BITS-1:0];

  // Back: ring walk, expiry, push and result register.
  swfrm_back #(
    .RING_DEPTH (RING_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (b_valid),
    .q_ready          (b_ready),
    .q_kind           (b_kind),
    .q_now            (b_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_delta      (frame_delta),
    .elapsed_time     (elapsed_time),
    .frames_in_window (frames_in_window)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING_SLOTS    = 256;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  // Start items give no result, so a settling pause is allowed to drain them
  // before a register write or the final verdict.
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned EVENT_SLOTS   = 4096;
  localparam int unsigned RESULT_SLOTS  = 4096;

  localparam logic START_CODE = swfrm_pkg::MODE_START;
  localparam logic FRAME_CODE = swfrm_pkg::EV_FRAME;

  typedef struct packed {
    logic [31:0] delta;
    logic [47:0] elapsed;
    logic [8:0]  count;
  } frame_result_t;

  // One stimulus item. Rows with 'typed' set carry a result worked out by
  // hand; all other frame items are checked against the predictor.
  typedef struct packed {
    logic          mode;
    logic [47:0]   stamp;
    logic          typed;
    frame_result_t want;
  } event_row_t;

  localparam int unsigned DIRECTED_COUNT = 18;
  localparam event_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // frame before any start: previous stamp is the reset start time (0)
    '{FRAME_CODE, 48'd100,             1'b1, '{32'd100,   48'd100,     9'd1}},
    '{START_CODE, 48'd1000,            1'b0, '0},
    '{FRAME_CODE, 48'd1000,            1'b1, '{32'd0,     48'd0,       9'd2}},
    // delta exactly at the reset cap, then one tick past it
    '{FRAME_CODE, 48'd51000,           1'b1, '{32'd50000, 48'd50000,   9'd3}},
    '{FRAME_CODE, 48'd101001,          1'b1, '{32'd50000, 48'd100001,  9'd4}},
    // time ran backward: zero delta, elapsed wraps, nothing expires
    '{FRAME_CODE, 48'd500,             1'b1, '{32'd0, 48'hFFFF_FFFF_FE0C, 9'd5}},
    // largest stamp: everything stored expires
    '{FRAME_CODE, 48'hFFFF_FFFF_FFFF,  1'b1, '{32'd50000, 48'hFFFF_FFFF_FC17, 9'd1}},
    '{START_CODE, 48'd0,               1'b0, '0},
    '{FRAME_CODE, 48'd0,               1'b1, '{32'd0,     48'd0,       9'd2}},
    // age equal to the window survives, one tick more does not
    '{FRAME_CODE, 48'd1000000,         1'b1, '{32'd50000, 48'd1000000, 9'd3}},
    '{FRAME_CODE, 48'd1000001,         1'b1, '{32'd1,     48'd1000001, 9'd2}},
    '{START_CODE, 48'h8000_0000_0000,  1'b0, '0},
    '{FRAME_CODE, 48'h8000_0000_0001,  1'b1, '{32'd1,     48'd1,       9'd2}},
    '{FRAME_CODE, 48'h8000_0001_0000,  1'b0, '0},
    '{FRAME_CODE, 48'h7FFF_FFFF_FFFF,  1'b0, '0},
    '{FRAME_CODE, 48'hAAAA_5555_AAAA,  1'b0, '0},
    '{START_CODE, 48'h5555_AAAA_5555,  1'b0, '0},
    '{FRAME_CODE, 48'h5555_AAAA_5556,  1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [47:0] now_time;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] frame_delta;
  logic [47:0] elapsed_time;
  logic [8:0]  frames_in_window;

  sliding_window_frame_rate_meter u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .now_time         (now_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_delta      (frame_delta),
    .elapsed_time     (elapsed_time),
    .frames_in_window (frames_in_window)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: a ring of time stamps, oldest first.
  // ---------------------------------------------------------------------
  logic [47:0] stamp_hist [RING_SLOTS];
  logic [7:0]  oldest_slot;
  int unsigned stamps_held;
  logic [47:0] run_origin;
  logic [31:0] window_len;
  logic [31:0] delta_cap;

  // Items waiting to be driven and results waiting to be seen; each list
  // has a running write count and a running read count.
  event_row_t    event_list [EVENT_SLOTS];
  int unsigned   events_queued;
  int unsigned   events_taken;
  frame_result_t expect_list [RESULT_SLOTS];
  int unsigned   expects_added;
  int unsigned   expects_done;

  bit          steady_flow;   // no idling on either side while set
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned events_sent;
  int unsigned starts_sent;
  int unsigned full_ring_hits;
  int unsigned backward_frames;
  int unsigned settings_used;
  int unsigned cycles;

  function automatic logic [7:0] slot_after(int unsigned offset);
    return oldest_slot + offset[7:0];
  endfunction

  // Append a stamp; a full ring loses its oldest entry.
  function automatic void store_stamp(logic [47:0] t);
    if (stamps_held >= RING_SLOTS) begin
      oldest_slot = slot_after(1);
      stamps_held = RING_SLOTS - 1;
    end
    stamp_hist[slot_after(stamps_held)] = t;
    stamps_held++;
  endfunction

  function automatic void add_event(event_row_t ev);
    event_list[events_queued % EVENT_SLOTS] = ev;
    events_queued++;
  endfunction

  function automatic void add_expect(frame_result_t r);
    expect_list[expects_added % RESULT_SLOTS] = r;
    expects_added++;
  endfunction

  // Advances the meter by one item; returns 1 when the item yields a result.
  function automatic bit meter_step(input logic m, input logic [47:0] t,
                                    output frame_result_t r);
    logic [47:0] prev;
    logic [47:0] gap;
    logic [47:0] front;
    r = '0;
    if (m == START_CODE) begin
      run_origin  = t;
      oldest_slot = '0;
      stamps_held = 0;
      store_stamp(t);
      return 1'b0;
    end
    // empty ring (only right after reset): measure from the start time
    prev = (stamps_held > 0) ? stamp_hist[slot_after(stamps_held - 1)] : run_origin;
    if (t < prev) begin
      r.delta = '0;
      backward_frames++;
    end else begin
      gap = t - prev;
      r.delta = (gap > {16'd0, delta_cap}) ? delta_cap : gap[31:0];
    end
    r.elapsed = t - run_origin;
    // drop stamps older than the window; a stamp newer than t stops the walk
    while (stamps_held > 0) begin
      front = stamp_hist[oldest_slot];
      if (t < front || (t - front) <= {16'd0, window_len}) break;
      oldest_slot = slot_after(1);
      stamps_held--;
    end
    store_stamp(t);
    r.count = stamps_held[8:0];
    if (stamps_held == RING_SLOTS) full_ring_hits++;
    return 1'b1;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic event_row_t make_event(logic m, logic [47:0] t);
    event_row_t ev;
    ev = '0;
    ev.mode  = m;
    ev.stamp = t;
    return ev;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: payload changes on the falling edge, acceptance is seen
  // on the rising edge. Valid is only dropped when a gap follows, so it is
  // never lowered and raised in the same step.
  // ---------------------------------------------------------------------
  task automatic send_events();
    event_row_t    ev;
    int unsigned   gap;
    frame_result_t predicted;
    bit            has_result;
    @(negedge clk);
    while (events_taken != events_queued) begin
      ev  = event_list[events_taken % EVENT_SLOTS];
      events_taken++;
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      mode     <= ev.mode;
      now_time <= ev.stamp;
      do @(posedge clk); while (!in_ready);
      has_result = meter_step(ev.mode, ev.stamp, predicted);
      if (has_result) add_expect(ev.typed ? ev.want : predicted);
      events_sent++;
      if (ev.mode == START_CODE) starts_sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Registers change only with the meter idle: all results in, then a pause
  // for start items that may still sit in the queue.
  task automatic set_meter(input logic [31:0] win, input logic [31:0] cap);
    while (expects_done != expects_added) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= swfrm_pkg::CFG_WINDOW;
    cfg_data  <= win;
    @(negedge clk);
    cfg_index <= swfrm_pkg::CFG_CAP;
    cfg_data  <= cap;
    @(negedge clk);
    cfg_write  <= 1'b0;
    window_len = win;
    delta_cap  = cap;
    settings_used++;
  endtask

  // One run: a start, then frames moving mostly forward in steps scaled to
  // the window, with jumps past the window, backward steps, wild stamps and
  // stray restarts mixed in. Dense runs use small steps only, to fill the ring.
  task automatic queue_run(input int unsigned n_frames, input int unsigned step_shift,
                           input bit dense);
    logic [47:0] t;
    logic [31:0] step_max;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) t = rand_stamp();
    else if (pick < 8) t = $urandom_range(0, 1000);
    else t = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 5000000);  // wraps soon
    step_max = window_len >> step_shift;
    if (step_max == 0) step_max = 1;
    add_event(make_event(START_CODE, t));
    for (int unsigned i = 0; i < n_frames; i++) begin
      pick = dense ? 0 : $urandom_range(0, 99);
      if (pick < 70) begin
        t = t + $urandom_range(0, step_max);
      end else if (pick < 80) begin
        t = t + $urandom_range(0, window_len);
      end else if (pick < 87) begin
        t = t + window_len + $urandom_range(1, step_max);
      end else if (pick < 93) begin
        t = t - $urandom_range(1, 4 * step_max);
      end else if (pick < 97) begin
        t = rand_stamp();
      end else begin
        add_event(make_event(START_CODE, t));
        continue;
      end
      add_event(make_event(FRAME_CODE, t));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, compare against the oldest expectation.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  function automatic void flag_field(string field, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expects_done == expects_added) begin
        $display("%0t: result with nothing expected, expected none, got %0d/%0d/%0d",
                 $time, frame_delta, elapsed_time, frames_in_window);
        mismatches++;
      end else begin
        want = expect_list[expects_done % RESULT_SLOTS];
        expects_done++;
        flag_field("frame_delta", {16'd0, want.delta}, {16'd0, frame_delta});
        flag_field("elapsed_time", want.elapsed, elapsed_time);
        flag_field("frames_in_window", {39'd0, want.count}, {39'd0, frames_in_window});
        results_checked++;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expects_added - expects_done);
      $display("** sliding_window_frame_rate_meter: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] phase_window [PHASES];
    logic [31:0] phase_cap [PHASES];
    int unsigned phase_items;
    int unsigned run_len;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = swfrm_pkg::CFG_WINDOW;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = START_CODE;
    now_time  = '0;

    oldest_slot = '0;
    stamps_held = 0;
    run_origin  = '0;
    window_len  = swfrm_pkg::WINDOW_RESET;
    delta_cap   = swfrm_pkg::CAP_RESET;
    events_queued = 0;
    events_taken  = 0;
    expects_added = 0;
    expects_done  = 0;
    steady_flow = 1'b0;
    mismatches = 0;
    results_checked = 0;
    events_sent = 0;
    starts_sent = 0;
    full_ring_hits = 0;
    backward_frames = 0;
    settings_used = 1;
    cycles = 0;

    // Phases 0 and 6 keep the reset values; the others sweep extremes and randoms.
    phase_window[0] = swfrm_pkg::WINDOW_RESET;    phase_cap[0] = swfrm_pkg::CAP_RESET;
    phase_window[1] = 32'd1;                      phase_cap[1] = 32'd0;
    phase_window[2] = 32'hFFFF_FFFF;              phase_cap[2] = 32'hFFFF_FFFF;
    phase_window[3] = $urandom_range(16, 4096);   phase_cap[3] = $urandom_range(0, 100);
    phase_window[4] = $urandom_range(1, 32'hFFFF_FFFF);
    phase_cap[4]    = $urandom;
    phase_window[5] = 32'd5000;                   phase_cap[5] = 32'hFFFF_FFFF;
    phase_window[6] = swfrm_pkg::WINDOW_RESET;    phase_cap[6] = swfrm_pkg::CAP_RESET;
    phase_window[7] = $urandom_range(1, 64);      phase_cap[7] = $urandom_range(0, 64);

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the reset register values.
    for (int unsigned i = 0; i < DIRECTED_COUNT; i++) add_event(DIRECTED_ROWS[i]);
    send_events();

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p > 0) set_meter(phase_window[p], phase_cap[p]);
      steady_flow = (p == 6);
      phase_items = 0;
      if (p == 0) begin
        // long dense run: the ring fills and stays saturated
        queue_run(300, 10, 1'b1);
        phase_items = 301;
      end
      while (phase_items < RANDOM_ITEMS / PHASES) begin
        run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(260, 320)
                                               : $urandom_range(4, 100);
        // keep the phase near its share of the item budget
        if (phase_items + run_len + 1 > RANDOM_ITEMS / PHASES)
          run_len = RANDOM_ITEMS / PHASES - phase_items - 1;
        queue_run(run_len, $urandom_range(3, 10), 1'b0);
        phase_items += run_len + 1;
      end
      send_events();
    end

    while (expects_done != expects_added) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d items (%0d run starts) and checked %0d results over %0d settings",
             events_sent, starts_sent, results_checked, settings_used);
    $display("Ring reached full depth %0d times; %0d frames arrived with time running backward",
             full_ring_hits, backward_frames);
    if (mismatches == 0) begin
      $display("** sliding_window_frame_rate_meter: PASSED **");
    end else begin
      $display("** sliding_window_frame_rate_meter: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/swfrm_pkg.sv
src/swfrm_front.sv
src/swfrm_queue.sv
src/swfrm_back.sv
src/sliding_window_frame_rate_meter.sv
bench/testbench.sv
